[rtl/mt64_pkg.sv]
// ----------------------------------------------------------------------------
// mt64_pkg
// shared constants and word functions of the mt19937-64 generator
// ----------------------------------------------------------------------------
package mt64_pkg;

  localparam int unsigned STATE_DEPTH = 312;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned FRAC_W      = 53;
  localparam int unsigned FRAC_SHIFT  = VALUE_W - FRAC_W;

  localparam logic [VALUE_W-1:0] SEED_RESET   = 64'd5489;
  localparam logic [VALUE_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [VALUE_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [VALUE_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VALUE_W-1:0] FILL_MULT    = 64'd6364136223846793005;
  localparam logic [VALUE_W-1:0] TEMPER_B     = 64'h5555_5555_5555_5555;
  localparam logic [VALUE_W-1:0] TEMPER_C     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [VALUE_W-1:0] TEMPER_D     = 64'hFFF7_EEE0_0000_0000;

  // twist of one state word from its own, its neighbor and its far partner
  function automatic logic [VALUE_W-1:0] mix_pair(
    input logic [VALUE_W-1:0] hi_word,
    input logic [VALUE_W-1:0] lo_word,
    input logic [VALUE_W-1:0] far_word
  );
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
    x = (hi_word & UPPER_MASK) | (lo_word & LOWER_MASK);
    y = far_word ^ (x >> 1);
    if (x[0]) begin
      y = y ^ TWIST_MATRIX;
    end
    return y;
  endfunction

  // output tempering
  function automatic logic [VALUE_W-1:0] temper(input logic [VALUE_W-1:0] w);
    logic [VALUE_W-1:0] x;
    x = w;
    x = x ^ ((x >> 29) & TEMPER_B);
    x = x ^ ((x << 17) & TEMPER_C);
    x = x ^ ((x << 37) & TEMPER_D);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

[rtl/mt64_if.sv]
// ----------------------------------------------------------------------------
// mt64 stream interfaces
// request channel (restart flag) and result channel (value and fraction)
// ----------------------------------------------------------------------------
interface mt64_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mt64_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mt64_pkg::VALUE_W-1:0]     value;
  logic [mt64_pkg::FRAC_W-1:0]      fraction;

  modport source (output valid, output value, output fraction, input ready);
  modport sink   (input valid, input value, input fraction, output ready);
endinterface

[rtl/mt64_ram.sv]
// ----------------------------------------------------------------------------
// mt64_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mt64_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 312
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mt64_19937_64_generator_core.sv]
// ----------------------------------------------------------------------------
// mt19937_64_generator_core
// one mt19937-64 generator: seed fill, lazy per-word twist, tempered draw
// ----------------------------------------------------------------------------
// a draw runs three reads of the single state ram read port (word at the
//   index, its neighbor, its far partner), one mix and write, and one output
//   load that waits for a free output slot; no new request is taken before that load
// a seed fill (first request after reset, or restart) writes the seed to word 0,
//   then 311 words, each from partials of one shared 32x32 multiplier
// reset: seed 5489, read index 312, not seeded; state ram is not cleared
// ----------------------------------------------------------------------------
module mt19937_64_generator_core #(
  parameter int unsigned StateDepth = mt64_pkg::STATE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         seed_we_i,
  input  logic [mt64_pkg::VALUE_W-1:0] seed_wdata_i,
  mt64_req_if.sink                     req_i,
  mt64_rsp_if.source                   rsp_o
);

  localparam int unsigned AddrW     = $clog2(StateDepth);
  localparam int unsigned IdxW      = $clog2(StateDepth + 1);
  localparam int unsigned HalfDepth = StateDepth / 2;
  localparam int unsigned VW        = mt64_pkg::VALUE_W;
  localparam int unsigned HW        = VW / 2;

  localparam logic [HW-1:0] MultLo = mt64_pkg::FILL_MULT[HW-1:0];
  localparam logic [HW-1:0] MultHi = mt64_pkg::FILL_MULT[VW-1:HW];

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL_SEED,  // word 0 takes the seed
    S_FILL_MUL,   // three partial products, one per cycle
    S_FILL_WR,    // combine partials, add index, write word
    S_RD0,        // read word at index
    S_RD1,        // read neighbor word
    S_RD2,        // read far partner word
    S_MIX,        // twist the word and write it back
    S_OUT         // temper into the output register
  } state_e;

  state_e            state_q;
  logic [VW-1:0]     seed_q;
  logic              seeded_q;
  logic [IdxW-1:0]   idx_q;        // equals StateDepth when a new twist round is due
  logic [AddrW-1:0]  fill_idx_q;
  logic [1:0]        fstep_q;
  logic [VW-1:0]     prev_q;       // last filled word
  logic [VW-1:0]     pll_q;        // lo x lo partial product
  logic [HW-1:0]     plh_q;        // lo x hi partial, low half only
  logic [HW-1:0]     phl_q;        // hi x lo partial, low half only
  logic [VW-1:0]     cur_q;
  logic [VW-1:0]     nxt_q;
  logic [VW-1:0]     mix_q;
  logic              out_valid_q;
  logic [VW-1:0]     out_value_q;

  // ram ports
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [VW-1:0]     ram_rdata;

  // fill datapath
  logic [VW-1:0]     fill_x;
  logic [HW-1:0]     mul_a;
  logic [HW-1:0]     mul_b;
  logic [VW-1:0]     mul_p;
  logic [HW-1:0]     cross_sum;
  logic [VW-1:0]     fill_word;

  // draw datapath
  logic [AddrW-1:0]  rd_idx;
  logic [AddrW-1:0]  nxt_idx;
  logic [AddrW-1:0]  far_idx;
  logic [VW-1:0]     mix_word;
  logic              slot_free;
  logic              req_beat;

  assign fill_x = prev_q ^ (prev_q >> 62);

  // one shared 32x32 multiplier, operands picked by the fill step
  always_comb begin
    unique case (fstep_q)
      2'd0:    begin mul_a = fill_x[HW-1:0];  mul_b = MultLo; end
      2'd1:    begin mul_a = fill_x[HW-1:0];  mul_b = MultHi; end
      default: begin mul_a = fill_x[VW-1:HW]; mul_b = MultLo; end
    endcase
  end
  assign mul_p = VW'(mul_a) * VW'(mul_b);

  // upper cross terms only matter modulo 2^64
  assign cross_sum = plh_q + phl_q;
  assign fill_word = pll_q + {cross_sum, {HW{1'b0}}} + VW'(fill_idx_q);

  assign rd_idx  = idx_q[AddrW-1:0];
  assign nxt_idx = (rd_idx == AddrW'(StateDepth - 1)) ? '0 : rd_idx + AddrW'(1);
  assign far_idx = (rd_idx < AddrW'(HalfDepth)) ? rd_idx + AddrW'(HalfDepth)
                                                : rd_idx - AddrW'(HalfDepth);

  // words below the index are already twisted this round, so the in-place
  // twist order is kept when each word is twisted right before its draw
  assign mix_word = mt64_pkg::mix_pair(cur_q, nxt_q, ram_rdata);

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_beat  = req_i.valid && req_i.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = mix_word;
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    unique case (state_q)
      S_FILL_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_q;
      end
      S_FILL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx_q;
        ram_wdata = fill_word;
      end
      S_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = rd_idx;
      end
      S_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = nxt_idx;
      end
      S_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = far_idx;
      end
      S_MIX: begin
        ram_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mt64_ram #(
    .Width (VW),
    .Depth (StateDepth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // seed register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mt64_pkg::SEED_RESET;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      idx_q       <= IdxW'(StateDepth);
      fill_idx_q  <= '0;
      fstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a result loaded in this cycle takes the slot over
      if (out_valid_q && rsp_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_beat) begin
            if (req_i.restart || !seeded_q) begin
              state_q <= S_FILL_SEED;
            end else begin
              if (idx_q == IdxW'(StateDepth)) begin
                idx_q <= '0;
              end
              state_q <= S_RD0;
            end
          end
        end
        S_FILL_SEED: begin
          prev_q     <= seed_q;
          fill_idx_q <= AddrW'(1);
          fstep_q    <= '0;
          state_q    <= S_FILL_MUL;
        end
        S_FILL_MUL: begin
          unique case (fstep_q)
            2'd0:    pll_q <= mul_p;
            2'd1:    plh_q <= mul_p[HW-1:0];
            default: phl_q <= mul_p[HW-1:0];
          endcase
          if (fstep_q == 2'd2) begin
            fstep_q <= '0;
            state_q <= S_FILL_WR;
          end else begin
            fstep_q <= fstep_q + 2'd1;
          end
        end
        S_FILL_WR: begin
          prev_q <= fill_word;
          if (fill_idx_q == AddrW'(StateDepth - 1)) begin
            // fill sets the index to zero, so the draw starts a new round
            seeded_q <= 1'b1;
            idx_q    <= '0;
            state_q  <= S_RD0;
          end else begin
            fill_idx_q <= fill_idx_q + AddrW'(1);
            state_q    <= S_FILL_MUL;
          end
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          cur_q   <= ram_rdata;
          state_q <= S_RD2;
        end
        S_RD2: begin
          nxt_q   <= ram_rdata;
          state_q <= S_MIX;
        end
        S_MIX: begin
          mix_q   <= mix_word;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= mt64_pkg::temper(mix_q);
            idx_q       <= idx_q + IdxW'(1);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.value    = out_value_q;
  assign rsp_o.fraction = out_value_q[VW-1:mt64_pkg::FRAC_SHIFT];

`ifndef SYNTHESIS
  // the single ram never sees a read and a write in the same cycle
  a_ram_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("state ram read and write in the same cycle");

  // every draw read happens on a seeded state with the index inside the ram
  a_draw_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> (seeded_q && (idx_q < IdxW'(StateDepth))))
    else $error("draw from unseeded state or index out of range");

  // loading a result advances the read index by one
  a_idx_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && slot_free) |=> (idx_q == $past(idx_q) + IdxW'(1)))
    else $error("read index did not advance on a draw");

  // once seeded, the generator stays seeded until reset
  a_seeded_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(seeded_q))
    else $error("seeded flag dropped");
`endif

endmodule

[tb/sv/mt19937_64_generator_core_tb.sv]
// ----------------------------------------------------------------------------
// mt19937_64_generator_core_tb
// self-checking bench for the mt19937-64 generator core
// scoreboard keeps its own 312-word state, read index, seeded flag and seed
// directed opening on seeds and restart, then random phases with stalls
// ----------------------------------------------------------------------------
module mt19937_64_generator_core_tb;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxGap      = 18;
  localparam int unsigned PhaseItems  = 300;
  localparam int unsigned LongHold    = 250;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned Depth       = mt64_pkg::STATE_DEPTH;
  localparam int unsigned HalfDepth   = Depth / 2;
  localparam int unsigned ValueW      = mt64_pkg::VALUE_W;
  localparam int unsigned FracW       = mt64_pkg::FRAC_W;
  localparam int unsigned FracShift   = mt64_pkg::FRAC_SHIFT;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [FracW-1:0]  fraction;
  } draw_result_t;

  // predicted generator: same draws as the block, checked beat by beat
  class mt_draw_board;
    logic [ValueW-1:0]  seed_reg;
    logic [ValueW-1:0]  words [Depth];
    int unsigned        rd_idx;
    bit                 seeded;
    draw_result_t       pending [$];
    int unsigned        errors;
    int unsigned        draws;
    int unsigned        restarts;
    int unsigned        twists;
    int unsigned        fills;

    function new();
      seed_reg = mt64_pkg::SEED_RESET;
      rd_idx   = Depth;
      seeded   = 1'b0;
      errors   = 0;
      draws    = 0;
      restarts = 0;
      twists   = 0;
      fills    = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // fill all words from the seed register
    function void load_seed();
      logic [ValueW-1:0] prev;
      words[0] = seed_reg;
      for (int unsigned i = 1; i < Depth; i++) begin
        prev     = words[i-1];
        words[i] = mt64_pkg::FILL_MULT * (prev ^ (prev >> 62)) + ValueW'(i);
      end
      rd_idx = Depth;
      seeded = 1'b1;
      fills++;
    endfunction

    // regenerate the whole block of words in place
    function void regenerate();
      logic [ValueW-1:0] joined;
      logic [ValueW-1:0] mixed;
      int unsigned       nxt;
      int unsigned       far_idx;
      for (int unsigned i = 0; i < Depth; i++) begin
        nxt     = (i + 1) % Depth;
        far_idx = (i + HalfDepth) % Depth;
        joined  = (words[i] & mt64_pkg::UPPER_MASK) | (words[nxt] & mt64_pkg::LOWER_MASK);
        mixed   = words[far_idx] ^ (joined >> 1);
        if (joined[0]) mixed = mixed ^ mt64_pkg::TWIST_MATRIX;
        words[i] = mixed;
      end
      rd_idx = 0;
      twists++;
    endfunction

    function logic [ValueW-1:0] scramble(input logic [ValueW-1:0] w);
      logic [ValueW-1:0] t;
      t = w;
      t = t ^ ((t >> 29) & mt64_pkg::TEMPER_B);
      t = t ^ ((t << 17) & mt64_pkg::TEMPER_C);
      t = t ^ ((t << 37) & mt64_pkg::TEMPER_D);
      t = t ^ (t >> 43);
      return t;
    endfunction

    // accepted request beat: advance the predicted state, queue the result
    function void note_request(input bit restart);
      draw_result_t r;
      if (restart || !seeded) load_seed();
      if (rd_idx >= Depth) regenerate();
      r.value    = scramble(words[rd_idx]);
      r.fraction = r.value[ValueW-1:FracShift];
      rd_idx++;
      pending.push_back(r);
      draws++;
      if (restart) restarts++;
    endfunction

    task report(input string msg);
      if (errors < 30) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // result beat: compare each field with the oldest expected draw
    task check_result(input logic [ValueW-1:0] value, input logic [FracW-1:0] fraction);
      draw_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("result beat with no draw pending, value %h", value));
      end else begin
        exp_r = pending.pop_front();
        if (value !== exp_r.value)
          report($sformatf("value %h, predicted %h", value, exp_r.value));
        if (fraction !== exp_r.fraction)
          report($sformatf("fraction %h, predicted %h", fraction, exp_r.fraction));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              seed_we_i;
  logic [ValueW-1:0] seed_wdata_i;

  mt64_req_if req_if ();
  mt64_rsp_if rsp_if ();

  mt_draw_board board = new();

  // cleared for stretches where neither side idles
  bit          idle_on = 1'b1;
  int unsigned seed_writes = 0;

  mt19937_64_generator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_wdata_i(seed_wdata_i),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: the slowest legal run is far below this
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d draws still pending", cycles,
                 board.pending.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stall per beat, plus long hold-offs so the core
  // backs up and stops taking requests
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned beats;
    stall_left = 0;
    beats      = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        board.check_result(rsp_if.value, rsp_if.fraction);
        beats++;
        stall_left = idle_on ? $urandom_range(0, MaxGap) : 0;
        // long hold-off, counted here while the sender keeps offering
        if (beats == 40 || beats == 700) stall_left = LongHold;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // one request beat; valid stays high across back-to-back beats
  task automatic send_draw(input bit restart);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    board.note_request(restart);
  endtask

  // stop offering and wait for every predicted result, then let the core
  // settle so a seed write lands on an idle block
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [ValueW-1:0] seed);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= seed;
    @(posedge clk_i);
    seed_we_i    <= 1'b0;
    board.seed_reg = seed;
    seed_writes++;
  endtask

  initial begin : stimulus
    int unsigned       restart_permille [4];
    logic [ValueW-1:0] seed;
    bit                rs;

    restart_permille = '{3, 40, 0, 8};

    rst_ni         <= 1'b0;
    seed_we_i      <= 1'b0;
    seed_wdata_i   <= '0;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed opening ---
    // first request after reset fills from the reset seed even without restart
    send_draw(1'b0);
    repeat (3) send_draw(1'b0);
    // restart on the reset seed replays the sequence from its start
    send_draw(1'b1);
    send_draw(1'b0);

    // seed zero
    drain_results();
    write_seed('0);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);

    // seed written after seeding: no effect until a restart
    drain_results();
    write_seed('1);
    repeat (3) send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);

    // top and bottom bits set
    drain_results();
    write_seed({1'b1, {(ValueW-2){1'b0}}, 1'b1});
    send_draw(1'b1);
    send_draw(1'b1);
    send_draw(1'b0);

    // --- random phases ---
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        1:       seed = mt64_pkg::SEED_RESET;
        3:       seed = {1'b1, 31'($urandom), 32'($urandom)};
        default: seed = {32'($urandom), 32'($urandom)};
      endcase
      write_seed(seed);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // a window of full-rate traffic on both sides
        idle_on = !(n >= 100 && n < 160);
        // sender pauses until the core has handed back everything
        if (ph == 2 && n == 150) drain_results();
        // the last phase starts on the old state despite its new seed, until a random restart
        rs = (n == 0 && ph != 3) || ($urandom_range(0, 999) < restart_permille[ph]);
        send_draw(rs);
      end
    end
    idle_on = 1'b1;

    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d draws never returned", board.pending.size()));

    $display("run covered %0d draws (%0d with restart) over %0d seed values",
             board.draws, board.restarts, seed_writes + 1);
    $display("state refills: %0d, full state regenerations: %0d, mismatches: %0d",
             board.fills, board.twists, board.errors);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
